/* hdl/linear_scatter_line_resampler_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the line resampler
// Concurrent checks on clk, disabled while rst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef LINEAR_SCATTER_LINE_RESAMPLER_TOP_ASSERT_SVH
`define LINEAR_SCATTER_LINE_RESAMPLER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LSR_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("lsr invariant violated");
`define LSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsr sequence violated");
`else
`define LSR_ASSERT_ALWAYS(lbl, cond)
`define LSR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/lsr_pkg.sv */
// ----------------------------------------------------------------------------
// lsr_pkg
// Shared constants, register codes and types of the line resampler.
// ----------------------------------------------------------------------------
package lsr_pkg;

  localparam int unsigned MAX_LINE  = 4096;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned COLOR_W   = 16;
  localparam int unsigned LEN_W     = $clog2(MAX_LINE);

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_SOURCE_LENGTH = 1'b0;
  localparam reg_idx_t REG_TARGET_LENGTH = 1'b1;

  typedef struct packed {
    logic clear;
    logic accum;
    logic shift;
    logic load;
    logic iter;
  } lane_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RATIO = 5'b00010,
    ST_POS   = 5'b00100,
    ST_LOAD  = 5'b01000,
    ST_DIV   = 5'b10000
  } state_t;

endpackage

/* hdl/lsr_rdiv.sv */
// ----------------------------------------------------------------------------
// lsr_rdiv
// Restoring divider, one quotient bit a cycle, for the per-line step ratio.
// ----------------------------------------------------------------------------
module lsr_rdiv
  import lsr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = lsr_pkg::FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [LEN_W+FRAC_BITS-1:0] span,
  input  logic [LEN_W-1:0]           divisor,
  output logic                       done,
  output logic [LEN_W+FRAC_BITS-1:0] quot,
  output logic [LEN_W-1:0]           rem
);

  localparam int unsigned NUM_W = LEN_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] dv_r, dv_nxt;
  logic [LEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, dv_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = span;
      rem_nxt  = '0;
      dv_nxt   = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? LEN_W'(trial - {1'b0, dv_r}) : trial[LEN_W-1:0];
      q_nxt   = {q_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

/* hdl/lsr_lane.sv */
// ----------------------------------------------------------------------------
// lsr_lane
// One colour channel: weighted sums of both open slots and a serial divider
// that normalises the closing slot.
// ----------------------------------------------------------------------------
module lsr_lane
  import lsr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = lsr_pkg::FRAC_BITS
) (
  input  logic                     clk,
  input  lane_ctl_t                ctl,
  input  logic [COLOR_W-1:0]       color,
  input  logic [FRAC_BITS:0]       w0,
  input  logic [FRAC_BITS:0]       w1,
  input  logic [FRAC_BITS+12:0]    den,
  output logic [COLOR_W-1:0]       quot
);

  localparam int unsigned SUM_W = 28 + FRAC_BITS;
  localparam int unsigned REM_W = FRAC_BITS + 13;

  logic [SUM_W-1:0]   sum0_r, sum0_nxt;
  logic [SUM_W-1:0]   sum1_r, sum1_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [COLOR_W-1:0] q_r, q_nxt;
  logic [FRAC_BITS+COLOR_W:0] prod0, prod1;
  logic [REM_W:0]     trial;
  logic               ge;

  assign prod0 = w0 * color;
  assign prod1 = w1 * color;
  assign trial = {rem_r, q_r[COLOR_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_comb begin
    sum0_nxt = sum0_r;
    sum1_nxt = sum1_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (ctl.clear) begin
      sum0_nxt = '0;
      sum1_nxt = '0;
    end else if (ctl.accum) begin
      sum0_nxt = (ctl.shift ? sum1_r : sum0_r) + SUM_W'(prod0);
      sum1_nxt = (ctl.shift ? '0 : sum1_r) + SUM_W'(prod1);
    end
    // snapshot the slot before it moves on
    if (ctl.load) begin
      rem_nxt = REM_W'(sum0_r[SUM_W-1:COLOR_W]);
      q_nxt   = sum0_r[COLOR_W-1:0];
    end else if (ctl.iter) begin
      rem_nxt = ge ? REM_W'(trial - {1'b0, den}) : trial[REM_W-1:0];
      q_nxt   = {q_r[COLOR_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    sum0_r <= sum0_nxt;
    sum1_r <= sum1_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
  end

  assign quot = q_r;

endmodule

/* hdl/linear_scatter_line_resampler_top.sv */
// ----------------------------------------------------------------------------
// Linear scatter line resampler
// Downscales a line of RGB pixels by splitting each between two output slots
// with linear weights; each closed slot is normalised by its weight sum.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_red_in, in_green_in, in_blue_in
//   out_    | output    | out_valid/out_stall| out_*_out, out_line_end
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each item is weighted in ST_POS; a slot it closes then passes through the 16-step
// serial divider of the colour lanes, the last pixel of a line also flushes the
// open slot through it, and the first pixel of a line first waits in ST_RATIO
// for the step ratio divider.
// Reset is synchronous; no clearing pass is needed.
// A stalled output holds the divider result until the transaction completes.
// ----------------------------------------------------------------------------
`include "linear_scatter_line_resampler_top_assert.svh"

module linear_scatter_line_resampler_top
  import lsr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = lsr_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COLOR_W-1:0] in_red_in,
  input  logic [COLOR_W-1:0] in_green_in,
  input  logic [COLOR_W-1:0] in_blue_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] out_red_out,
  output logic [COLOR_W-1:0] out_green_out,
  output logic [COLOR_W-1:0] out_blue_out,
  output logic               out_line_end,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  reg_idx_t           cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int unsigned POS_W     = LEN_W + FRAC_BITS;
  localparam int unsigned WSUM_W    = FRAC_BITS + 13;
  localparam int unsigned DIV_STEPS = COLOR_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   cfg_src_r, cfg_src_nxt, cfg_tgt_r, cfg_tgt_nxt;
  logic [CFG_W-1:0]   line_src_r, line_src_nxt, line_tgt_r, line_tgt_nxt;
  logic [LEN_W-1:0]   src_idx_r, src_idx_nxt, open_r, open_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [FRAC_BITS:0] step_r, step_nxt;
  logic [LEN_W-1:0]   step_rem_r, step_rem_nxt, rem_acc_r, rem_acc_nxt;
  logic [WSUM_W-1:0]  wsum0_r, wsum0_nxt, wsum1_r, wsum1_nxt, den_r, den_nxt;
  logic [COLOR_W-1:0] pix_r [3];
  logic               last_pend_r, last_pend_nxt, line_end_r, line_end_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] out_col_r [3];
  logic               out_end_r;
  logic               out_load;

  logic               in_acc;
  logic [CFG_W-1:0]   s_cl, t_cl, s_m1, t_m1, ln_s_m1, ln_t_m1;
  logic               rd_start, rd_done;
  logic [POS_W-1:0]   rd_quot;
  logic [LEN_W-1:0]   rd_rem;
  logic               last;
  logic [POS_W-1:0]   pos_cur;
  logic [LEN_W-1:0]   xx;
  logic [FRAC_BITS-1:0] frac;
  logic               close;
  logic [FRAC_BITS:0] w0, w1;
  logic [CFG_W-1:0]   acc_sum;
  lane_ctl_t          lctl;
  logic [COLOR_W-1:0] lane_q [3];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;

  // clamp the lengths for the coming line
  always_comb begin
    if (cfg_src_r < CFG_W'(2)) s_cl = CFG_W'(2);
    else if (cfg_src_r > CFG_W'(MAX_LINE)) s_cl = CFG_W'(MAX_LINE);
    else s_cl = cfg_src_r;
    if (cfg_tgt_r < CFG_W'(1)) t_cl = CFG_W'(1);
    else if (cfg_tgt_r > s_cl) t_cl = s_cl;
    else t_cl = cfg_tgt_r;
  end
  assign s_m1    = s_cl - CFG_W'(1);
  assign t_m1    = t_cl - CFG_W'(1);
  assign ln_s_m1 = line_src_r - CFG_W'(1);
  assign ln_t_m1 = line_tgt_r - CFG_W'(1);

  assign rd_start = in_acc && (src_idx_r == '0);

  lsr_rdiv #(.FRAC_BITS(FRAC_BITS)) u_rdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rd_start),
    .span    ({t_m1[LEN_W-1:0], {FRAC_BITS{1'b0}}}),
    .divisor (s_m1[LEN_W-1:0]),
    .done    (rd_done),
    .quot    (rd_quot),
    .rem     (rd_rem)
  );

  assign last    = {1'b0, src_idx_r} >= ln_s_m1;
  assign pos_cur = last ? {ln_t_m1[LEN_W-1:0], {FRAC_BITS{1'b0}}} : pos_r;
  assign xx      = pos_cur[POS_W-1:FRAC_BITS];
  assign frac    = pos_cur[FRAC_BITS-1:0];
  assign close   = xx > open_r;
  assign w0      = ONE - {1'b0, frac};
  assign w1      = ({1'b0, xx} + CFG_W'(1) < line_tgt_r) ? {1'b0, frac} : '0;
  assign acc_sum = {1'b0, rem_acc_r} + {1'b0, step_rem_r};
  assign out_load = (state_r == ST_DIV) && (cnt_r == CNT_W'(DIV_STEPS))
                    && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    cfg_src_nxt   = cfg_src_r;
    cfg_tgt_nxt   = cfg_tgt_r;
    line_src_nxt  = line_src_r;
    line_tgt_nxt  = line_tgt_r;
    src_idx_nxt   = src_idx_r;
    open_nxt      = open_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    step_rem_nxt  = step_rem_r;
    rem_acc_nxt   = rem_acc_r;
    wsum0_nxt     = wsum0_r;
    wsum1_nxt     = wsum1_r;
    den_nxt       = den_r;
    last_pend_nxt = last_pend_r;
    line_end_nxt  = line_end_r;
    cnt_nxt       = cnt_r;
    lctl          = '0;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOURCE_LENGTH: cfg_src_nxt = cfg_data;
        REG_TARGET_LENGTH: cfg_tgt_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (src_idx_r == '0) begin
            line_src_nxt = s_cl;
            line_tgt_nxt = t_cl;
            pos_nxt      = '0;
            rem_acc_nxt  = '0;
            open_nxt     = '0;
            wsum0_nxt    = '0;
            wsum1_nxt    = '0;
            lctl.clear   = 1'b1;
            state_nxt    = ST_RATIO;
          end else begin
            state_nxt = ST_POS;
          end
        end
      end
      ST_RATIO: begin
        if (rd_done) begin
          step_nxt     = rd_quot[FRAC_BITS:0];
          step_rem_nxt = rd_rem;
          state_nxt    = ST_POS;
        end
      end
      ST_POS: begin
        lctl.accum = 1'b1;
        lctl.shift = close;
        lctl.load  = close;
        wsum0_nxt  = (close ? wsum1_r : wsum0_r) + WSUM_W'(w0);
        wsum1_nxt  = (close ? '0 : wsum1_r) + WSUM_W'(w1);
        if (close) begin
          open_nxt = xx;
          den_nxt  = wsum0_r;
        end
        if (last) begin
          src_idx_nxt = '0;
        end else begin
          src_idx_nxt = src_idx_r + LEN_W'(1);
          if (acc_sum >= ln_s_m1) begin
            rem_acc_nxt = LEN_W'(acc_sum - ln_s_m1);
            pos_nxt     = pos_cur + POS_W'(step_r) + POS_W'(1);
          end else begin
            rem_acc_nxt = acc_sum[LEN_W-1:0];
            pos_nxt     = pos_cur + POS_W'(step_r);
          end
        end
        if (close) begin
          last_pend_nxt = last;
          line_end_nxt  = 1'b0;
          cnt_nxt       = '0;
          state_nxt     = ST_DIV;
        end else if (last) begin
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOAD: begin
        lctl.load     = 1'b1;
        den_nxt       = wsum0_r;
        line_end_nxt  = 1'b1;
        last_pend_nxt = 1'b0;
        cnt_nxt       = '0;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r != CNT_W'(DIV_STEPS)) begin
          lctl.iter = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else if (out_load) begin
          state_nxt = last_pend_r ? ST_LOAD : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    lsr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk   (clk),
      .ctl   (lctl),
      .color (pix_r[g]),
      .w0    (w0),
      .w1    (w1),
      .den   (den_r),
      .quot  (lane_q[g])
    );
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_src_r   <= CFG_W'(2);
      cfg_tgt_r   <= CFG_W'(2);
      line_src_r  <= CFG_W'(2);
      line_tgt_r  <= CFG_W'(2);
      src_idx_r   <= '0;
      open_r      <= '0;
      pos_r       <= '0;
      step_r      <= '0;
      step_rem_r  <= '0;
      rem_acc_r   <= '0;
      wsum0_r     <= '0;
      wsum1_r     <= '0;
      last_pend_r <= 1'b0;
      line_end_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_src_r   <= cfg_src_nxt;
      cfg_tgt_r   <= cfg_tgt_nxt;
      line_src_r  <= line_src_nxt;
      line_tgt_r  <= line_tgt_nxt;
      src_idx_r   <= src_idx_nxt;
      open_r      <= open_nxt;
      pos_r       <= pos_nxt;
      step_r      <= step_nxt;
      step_rem_r  <= step_rem_nxt;
      rem_acc_r   <= rem_acc_nxt;
      wsum0_r     <= wsum0_nxt;
      wsum1_r     <= wsum1_nxt;
      last_pend_r <= last_pend_nxt;
      line_end_r  <= line_end_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    den_r <= den_nxt;
    if (in_acc) begin
      pix_r[0] <= in_red_in;
      pix_r[1] <= in_green_in;
      pix_r[2] <= in_blue_in;
    end
    // merge the lanes; an empty slot reads as zero
    if (out_load) begin
      for (int k = 0; k < 3; k++) begin
        out_col_r[k] <= (den_r == '0) ? '0 : lane_q[k];
      end
      out_end_r <= line_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_col_r[0];
  assign out_green_out = out_col_r[1];
  assign out_blue_out  = out_col_r[2];
  assign out_line_end  = out_end_r;

  `LSR_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_r != ST_IDLE)
  `LSR_ASSERT_ALWAYS(a_index_in_line, {1'b0, src_idx_r} < line_src_r)
  `LSR_ASSERT_ALWAYS(a_open_slot_in_line, {1'b0, open_r} < line_tgt_r)
  `LSR_ASSERT_ALWAYS(a_div_count_bound, cnt_r <= CNT_W'(DIV_STEPS))

endmodule

/* test/lsr_checker.sv */
// ----------------------------------------------------------------------------
// Line resampler scoreboard
// Watches the configuration, input and output channels, predicts every output
// pixel from the accepted source pixels and compares each output transaction.
// ----------------------------------------------------------------------------
module lsr_checker
  import lsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [COLOR_W-1:0] in_red,
  input  logic [COLOR_W-1:0] in_green,
  input  logic [COLOR_W-1:0] in_blue,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [COLOR_W-1:0] out_red,
  input  logic [COLOR_W-1:0] out_green,
  input  logic [COLOR_W-1:0] out_blue,
  input  logic               out_line_end,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  reg_idx_t           cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output int                 fail_count,
  output int                 pending_pixels
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        line_end;
  } pixel_t;

  pixel_t pixel_q[$];

  logic [12:0] src_len_reg, dst_len_reg;
  logic [63:0] src_idx, pos, step_q, step_rem, rem_acc, open_slot;
  logic [63:0] line_src, line_dst;
  logic [63:0] csum [6];
  logic [63:0] wsum [2];

  assign pending_pixels = pixel_q.size();

  function automatic logic [15:0] norm(logic [63:0] num, logic [63:0] den);
    return (den == 0) ? 16'd0 : 16'(num / den);
  endfunction

  function automatic pixel_t close_slot(logic le);
    pixel_t p;
    p.red = norm(csum[0], wsum[0]);
    p.green = norm(csum[1], wsum[0]);
    p.blue = norm(csum[2], wsum[0]);
    p.line_end = le;
    return p;
  endfunction

  task automatic resample_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    logic [63:0] one, s, t, span, xx, frac, w0, w1;
    logic [63:0] c [3];
    logic last;
    one = 64'd1 << FRAC_BITS;
    c[0] = r; c[1] = g; c[2] = b;
    if (src_idx == 0) begin
      s = src_len_reg; t = dst_len_reg;
      if (s < 2) s = 2;
      if (s > MAX_LINE) s = MAX_LINE;
      if (t < 1) t = 1;
      if (t > s) t = s;
      line_src = s; line_dst = t;
      span = (t - 1) << FRAC_BITS;
      step_q = span / (s - 1);
      step_rem = span % (s - 1);
      rem_acc = 0; pos = 0; open_slot = 0;
      for (int k = 0; k < 6; k++) csum[k] = 0;
      wsum[0] = 0; wsum[1] = 0;
    end
    last = src_idx >= line_src - 1;
    if (last) pos = (line_dst - 1) << FRAC_BITS;
    xx = pos >> FRAC_BITS;
    frac = pos & (one - 1);
    if (xx > open_slot) begin
      pixel_q = {pixel_q, close_slot(1'b0)};
      for (int k = 0; k < 3; k++) begin
        csum[k] = csum[3 + k];
        csum[3 + k] = 0;
      end
      wsum[0] = wsum[1]; wsum[1] = 0;
      open_slot = xx;
    end
    w0 = one - frac;
    w1 = (xx + 1 < line_dst) ? frac : 0;
    for (int k = 0; k < 3; k++) begin
      csum[k] += w0 * c[k];
      csum[3 + k] += w1 * c[k];
    end
    wsum[0] += w0;
    wsum[1] += w1;
    if (last) begin
      pixel_q = {pixel_q, close_slot(1'b1)};
      src_idx = 0;
    end else begin
      src_idx++;
      pos += step_q;
      rem_acc += step_rem;
      if (rem_acc >= line_src - 1) begin
        rem_acc -= line_src - 1;
        pos += 1;
      end
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      src_len_reg <= 13'd2; dst_len_reg <= 13'd2;
      src_idx = 0; line_src = 2; line_dst = 2;
      fail_count <= 0;
      pixel_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SOURCE_LENGTH) src_len_reg <= cfg_data;
        else if (cfg_index == REG_TARGET_LENGTH) dst_len_reg <= cfg_data;
      end
      if (in_valid && !in_stall) resample_pixel(in_red, in_green, in_blue);
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected output r=%h g=%h b=%h end=%b", $time,
                   out_red, out_green, out_blue, out_line_end);
          fail_count <= fail_count + 1;
        end else begin
          want = pixel_q.pop_front();
          if (want != {out_red, out_green, out_blue, out_line_end}) begin
            $display("%0t: expected r=%h g=%h b=%h end=%b, got r=%h g=%h b=%h end=%b",
                     $time, want.red, want.green, want.blue, want.line_end,
                     out_red, out_green, out_blue, out_line_end);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Line resampler testbench
// Writes line lengths between lines, streams source lines with random gaps
// and output back-pressure; the scoreboard checks every output pixel.
// ----------------------------------------------------------------------------
module testbench;
  import lsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, out_line_end;
  logic [COLOR_W-1:0] in_red, in_green, in_blue, out_red, out_green, out_blue;
  logic cfg_valid, cfg_ready;
  reg_idx_t cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int fail_count, pending_pixels, cycle_count;
  int idle_pct, hold_cycles;
  logic quiet_mode;

  linear_scatter_line_resampler_top dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_red_in(in_red), .in_green_in(in_green), .in_blue_in(in_blue),
    .out_valid, .out_stall,
    .out_red_out(out_red), .out_green_out(out_green), .out_blue_out(out_blue),
    .out_line_end, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  lsr_checker scoreboard (
    .clk, .rst_n, .in_valid, .in_stall, .in_red, .in_green, .in_blue,
    .out_valid, .out_stall, .out_red, .out_green, .out_blue, .out_line_end,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending_pixels
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 3000000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Output back-pressure; a long hold-off is requested through hold_cycles.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= (!quiet_mode && $urandom_range(99) < idle_pct);
      end
    end
  end

  // Leave cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Leave in_valid high; the next gap or the end of the line drops it.
  task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    while (!quiet_mode && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; in_red <= r; in_green <= g; in_blue <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain;
    while (pending_pixels != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic send_line(int src_len, int kind);
    logic [15:0] r, g, b;
    for (int i = 0; i < src_len; i++) begin
      r = $urandom; g = $urandom; b = $urandom;
      if (kind == 1) begin r = 16'hffff; g = 16'hffff; b = 16'hffff; end
      if (kind == 2) begin r = 16'h0; g = 16'h0; b = 16'h0; end
      send_pixel(r, g, b);
    end
    in_valid <= 1'b0;
  endtask

  task automatic line_setup(int s, int t);
    drain;
    write_reg(REG_SOURCE_LENGTH, CFG_W'(s));
    write_reg(REG_TARGET_LENGTH, CFG_W'(t));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int s, t, sent;
    rst_n = 1'b0; in_valid = 1'b0; cfg_valid = 1'b0;
    cfg_index = REG_SOURCE_LENGTH; cfg_data = '0;
    in_red = '0; in_green = '0; in_blue = '0;
    idle_pct = 38; hold_cycles = 0; quiet_mode = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Reset lengths, then extremes and clamps
    send_line(2, 1);
    send_line(2, 2);
    line_setup(3, 1);      // single output slot
    send_line(3, 0);
    line_setup(4, 4);      // one to one
    send_line(4, 1);
    line_setup(5, 9);      // target clamped to source
    send_line(5, 0);
    line_setup(0, 0);      // both clamped up
    send_line(2, 0);
    line_setup(7, 3);
    send_line(7, 0);

    // Long output hold-off while the source line is being sent
    line_setup(20, 13);
    hold_cycles = 400;
    send_line(20, 0);
    drain;

    // Random lines; no idling in the middle stretch
    sent = 0;
    while (sent < 500) begin
      quiet_mode = (sent > 200 && sent < 300);
      case ($urandom_range(9))
        0: begin s = $urandom_range(2, 24); t = s; end  // one to one
        1: begin s = $urandom_range(2, 12); t = 1; end
        default: begin s = $urandom_range(2, 24); t = $urandom_range(1, s); end
      endcase
      line_setup(s, t);
      if (s > MAX_LINE) s = MAX_LINE;
      send_line(s, 0);
      sent += s;
    end
    drain;
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
